// ===== hdl/fha_pkg.sv =====
// Shared types and constants for the fit hole allocator.
// No dependencies; used by fit_hole_allocator_core, fha_checker and the testbench.
`timescale 1ns / 1ps

package fha_pkg;

    // Default table geometry
    localparam int DEF_MAX_HOLES = 16;
    localparam int DEF_SIZE_BITS = 16;

    // Beat field widths
    localparam int HOLE_IDX_W = 4;
    localparam int AMOUNT_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_COUNT = 2'd1;

    localparam logic       POLICY_FIRST = 1'b0;
    localparam logic       POLICY_BEST  = 1'b1;
    localparam logic [4:0] HOLE_COUNT_RESET = 5'd16;

    // Command modes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [HOLE_IDX_W-1:0] hole_index;
        logic [AMOUNT_W-1:0]   amount;
    } alloc_cmd_t;

    typedef struct packed {
        logic                  granted;
        logic [HOLE_IDX_W-1:0] granted_hole;
        logic [AMOUNT_W-1:0]   remaining;
    } alloc_result_t;

endpackage

// ===== hdl/fit_hole_allocator_core.sv =====
// First-fit / best-fit hole allocator over a table of free-hole sizes.
// Operation: a load beat writes its hole and gives its result registered; a request scans the
// first min(hole_count, MAX_HOLES) entries through the hole table's single read port, one
// entry per cycle, followed by a compare and a write-back of the picked hole.
// One command at a time: a request holds busy high, and busy drops with the one-cycle done strobe.
// Reset: async active low; a clearing pass then zeroes every table entry (busy).
`timescale 1ns / 1ps

module fit_hole_allocator_core #(
    parameter int MAX_HOLES = fha_pkg::DEF_MAX_HOLES,
    parameter int SIZE_BITS = fha_pkg::DEF_SIZE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fha_pkg::alloc_cmd_t               cmd,
    output logic                              done,
    output fha_pkg::alloc_result_t            result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fha_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fha_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CNT_W = $clog2(MAX_HOLES + 1);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       iss_reg, iss_next;
    logic [CNT_W-1:0]       lim_reg, lim_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       pick_reg, pick_next;
    logic [SIZE_BITS-1:0]   best_reg, best_next;
    logic [SIZE_BITS-1:0]   amt_reg, amt_next;
    logic                   done_reg, done_next;
    fha_pkg::alloc_result_t result_reg, result_next;
    logic                   policy_reg, policy_next;
    logic [4:0]             count_reg, count_next;

    // Hole table: one write port, one registered read port
    logic [SIZE_BITS-1:0]   mem [MAX_HOLES];
    logic [SIZE_BITS-1:0]   rd_data_reg;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [SIZE_BITS-1:0]   wr_data;

    logic                   accept;
    logic                   load_in_range;
    logic [SIZE_BITS-1:0]   cmd_amt;
    logic [CNT_W-1:0]       limit;
    logic                   fits;
    logic                   take;
    logic [SIZE_BITS-1:0]   shrunk;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign accept        = start && !busy;
    assign cmd_amt       = SIZE_BITS'(cmd.amount);
    assign load_in_range = (32'(cmd.hole_index) < 32'(MAX_HOLES));
    assign limit         = (32'(count_reg) < 32'(MAX_HOLES)) ? CNT_W'(count_reg)
                                                             : CNT_W'(MAX_HOLES);

    // Candidate check on the entry read last cycle
    assign fits   = (rd_data_reg >= amt_reg);
    assign take   = cmp_valid_reg && fits &&
                    (!found_reg || (policy_reg == fha_pkg::POLICY_BEST && rd_data_reg < best_reg));
    assign shrunk = best_reg - amt_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        lim_next       = lim_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        amt_next       = amt_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        policy_next    = policy_reg;
        count_next     = count_reg;
        rd_en          = 1'b0;
        rd_addr        = iss_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = iss_reg[IDX_W-1:0];
        wr_data        = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fha_pkg::REG_FIT_POLICY: policy_next = cfg_data[0];
                fha_pkg::REG_HOLE_COUNT: count_next  = cfg_data[4:0];
                default: ;
            endcase
        end

        if (take)
        begin
            found_next = 1'b1;
            pick_next  = cmp_idx_reg;
            best_next  = rd_data_reg;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = iss_reg[IDX_W-1:0];
                wr_data  = '0;
                iss_next = iss_reg + 1'b1;
                if (iss_reg == CNT_W'(MAX_HOLES - 1))
                begin
                    iss_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.mode == fha_pkg::MODE_LOAD)
                    begin
                        wr_en   = load_in_range;
                        wr_addr = IDX_W'(cmd.hole_index);
                        wr_data = cmd_amt;
                        done_next                = 1'b1;
                        result_next.granted      = 1'b0;
                        result_next.granted_hole = cmd.hole_index;
                        result_next.remaining    = load_in_range ?
                                                   fha_pkg::AMOUNT_W'(cmd_amt) : '0;
                    end
                    else
                    begin
                        amt_next   = cmd_amt;
                        lim_next   = limit;
                        iss_next   = '0;
                        found_next = 1'b0;
                        state_next = (limit == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (iss_reg < lim_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = iss_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = iss_reg[IDX_W-1:0];
                    iss_next       = iss_reg + 1'b1;
                end
                else
                begin
                    // last compare lands at this edge
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pick_reg;
                    wr_data = shrunk;
                    result_next.granted      = 1'b1;
                    result_next.granted_hole = fha_pkg::HOLE_IDX_W'(pick_reg);
                    result_next.remaining    = fha_pkg::AMOUNT_W'(shrunk);
                end
                else
                begin
                    result_next = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            iss_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
            policy_reg    <= fha_pkg::POLICY_FIRST;
            count_reg     <= fha_pkg::HOLE_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
            policy_reg    <= policy_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg     <= lim_next;
        cmp_idx_reg <= cmp_idx_next;
        pick_reg    <= pick_next;
        best_reg    <= best_next;
        amt_reg     <= amt_next;
        result_reg  <= result_next;
    end

endmodule

// ===== hdl/fha_checker.sv =====
// Port-level checks for fit_hole_allocator_core, attached by bind.
// Depends on fha_pkg for the beat types and mode codes.
`timescale 1ns / 1ps

module fha_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input fha_pkg::alloc_cmd_t    cmd,
    input logic                   done,
    input fha_pkg::alloc_result_t result
);

    // A load beat answers in the next cycle with its index echoed and no grant
    a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.mode == fha_pkg::MODE_LOAD |=>
            done && !result.granted && result.granted_hole == $past(cmd.hole_index))
        else $error("load beat did not answer next cycle");

    // A request makes the block busy in the next cycle, with no result there
    a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.mode == fha_pkg::MODE_REQUEST |=> busy && !done)
        else $error("request did not occupy the block");

    // Results appear only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A refused request reports hole 0 and nothing remaining
    a_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.granted && $past(busy) |->
            result.granted_hole == '0 && result.remaining == '0)
        else $error("refusal carries nonzero fields");

endmodule

bind fit_hole_allocator_core fha_checker u_fha_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

// ===== tb/fit_hole_allocator_core_test.sv =====
// Self-checking testbench for fit_hole_allocator_core: directed table, then random phases.
// Depends on fha_pkg and fit_hole_allocator_core; keeps its own model of the hole table.
`timescale 1ns / 1ps

module fit_hole_allocator_core_test;
    import fha_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_HOLES;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS = 125;

    // Indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

    typedef struct {
        bit                    is_reg;
        alloc_cmd_t            cmd;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        bit                    pinned;
        alloc_result_t         want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    alloc_cmd_t            cmd;
    logic                  done;
    alloc_result_t         result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Mirror of the block's state
    logic [AMOUNT_W-1:0]   hole_sz [TABLE_DEPTH];
    logic                  fit_pol;
    logic [4:0]            hole_cnt;

    alloc_result_t         grant_q [$];
    alloc_result_t         head;
    plan_row_t             plan [$];
    int                    err_count;
    int                    quiet_cycles;
    bit                    burst;

    fit_hole_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Apply one command to the mirrored table and return the grant it yields
    function automatic alloc_result_t allocate_hole(input alloc_cmd_t c);
        alloc_result_t r;
        int            span;
        int            pick;
        int            j;
        bit            found;
        r = '0;
        if (c.mode == MODE_LOAD)
        begin
            hole_sz[c.hole_index] = c.amount;
            r.granted_hole = c.hole_index;
            r.remaining = c.amount;
            return r;
        end
        span = (hole_cnt < TABLE_DEPTH) ? int'(hole_cnt) : TABLE_DEPTH;
        found = 1'b0;
        pick = 0;
        for (j = 0; j < span; j++)
        begin
            if (hole_sz[j] >= c.amount)
            begin
                if (!found)
                begin
                    pick = j;
                    found = 1'b1;
                end
                else if (fit_pol == POLICY_BEST && hole_sz[j] < hole_sz[pick])
                begin
                    pick = j;
                end
            end
        end
        if (found)
        begin
            hole_sz[pick] = hole_sz[pick] - c.amount;
            r.granted = 1'b1;
            r.granted_hole = HOLE_IDX_W'(pick);
            r.remaining = hole_sz[pick];
        end
        return r;
    endfunction

    function automatic plan_row_t cmd_row(input logic m, input logic [HOLE_IDX_W-1:0] h,
                                          input logic [AMOUNT_W-1:0] a);
        plan_row_t row;
        row = '{default: '0};
        row.cmd.mode = m;
        row.cmd.hole_index = h;
        row.cmd.amount = a;
        return row;
    endfunction

    function automatic plan_row_t pinned_row(input logic m, input logic [HOLE_IDX_W-1:0] h,
                                             input logic [AMOUNT_W-1:0] a, input logic g,
                                             input logic [HOLE_IDX_W-1:0] gh,
                                             input logic [AMOUNT_W-1:0] rem);
        plan_row_t row;
        row = cmd_row(m, h, a);
        row.pinned = 1'b1;
        row.want.granted = g;
        row.want.granted_hole = gh;
        row.want.remaining = rem;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] ri,
                                          input logic [CFG_DATA_W-1:0] v);
        plan_row_t row;
        row = '{default: '0};
        row.is_reg = 1'b1;
        row.reg_idx = ri;
        row.reg_val = v;
        return row;
    endfunction

    // Random command shaped around the current table so that grants, exact fits and ties occur
    function automatic alloc_cmd_t draw_cmd();
        alloc_cmd_t          c;
        int                  roll;
        logic [AMOUNT_W-1:0] base;
        c.hole_index = HOLE_IDX_W'($urandom_range(0, 15));
        base = hole_sz[$urandom_range(0, TABLE_DEPTH - 1)];
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 40)
        begin
            c.mode = MODE_LOAD;
            if (roll < 25)
                c.amount = base;
            else if (roll < 30)
                c.amount = 16'hFFFF;
            else if (roll < 35)
                c.amount = '0;
            else if (roll < 80)
                c.amount = AMOUNT_W'($urandom_range(0, 1000));
            else
                c.amount = AMOUNT_W'($urandom_range(0, 65535));
        end
        else
        begin
            c.mode = MODE_REQUEST;
            if (roll < 35)
                c.amount = base;
            else if (roll < 60)
                c.amount = AMOUNT_W'($urandom_range(0, int'(base)));
            else if (roll < 70)
                c.amount = '0;
            else if (roll < 75)
                c.amount = 16'hFFFF;
            else if (roll < 90)
                c.amount = AMOUNT_W'($urandom_range(0, 1000));
            else
                c.amount = AMOUNT_W'($urandom_range(0, 65535));
        end
        return c;
    endfunction

    // Present one command; start stays high into the next call when there is no gap
    task automatic issue_cmd(input alloc_cmd_t c, input bit pinned, input alloc_result_t want,
                             input int gap);
        alloc_result_t guess;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        guess = allocate_hole(c);
        grant_q.push_back(pinned ? want : guess);
    endtask

    // Write one register once every outstanding grant has come back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (grant_q.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (ri == REG_FIT_POLICY)
            fit_pol = v[0];
        else if (ri == REG_HOLE_COUNT)
            hole_cnt = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (grant_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, got %h", $time, result);
                err_count++;
            end
            else
            begin
                head = grant_q.pop_front();
                if (result.granted !== head.granted)
                begin
                    $display("%0t: granted expected %0d got %0d",
                             $time, head.granted, result.granted);
                    err_count++;
                end
                if (result.granted_hole !== head.granted_hole)
                begin
                    $display("%0t: granted_hole expected %0d got %0d",
                             $time, head.granted_hole, result.granted_hole);
                    err_count++;
                end
                if (result.remaining !== head.remaining)
                begin
                    $display("%0t: remaining expected %0d got %0d",
                             $time, head.remaining, result.remaining);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("fit_hole_allocator_core_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [4:0] count_pick [RANDOM_PHASES];
        int         gap;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        err_count = 0;
        quiet_cycles = 0;
        burst = 1'b0;
        foreach (hole_sz[i]) hole_sz[i] = '0;
        fit_pol = POLICY_FIRST;
        hole_cnt = HOLE_COUNT_RESET;
        count_pick = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd16,
                       5'd3, 5'd15, 5'd12, 5'd16, 5'd5, 5'd24, 5'd16};

        plan = '{
            // empty table: a zero request fits hole 0, anything else is refused
            pinned_row(MODE_REQUEST, 4'd5, 16'd0, 1'b1, 4'd0, 16'd0),
            pinned_row(MODE_REQUEST, 4'd0, 16'd1, 1'b0, 4'd0, 16'd0),
            pinned_row(MODE_LOAD, 4'd15, 16'hFFFF, 1'b0, 4'd15, 16'hFFFF),
            pinned_row(MODE_REQUEST, 4'd15, 16'hFFFF, 1'b1, 4'd15, 16'd0),
            pinned_row(MODE_LOAD, 4'd2, 16'd300, 1'b0, 4'd2, 16'd300),
            pinned_row(MODE_LOAD, 4'd4, 16'd120, 1'b0, 4'd4, 16'd120),
            pinned_row(MODE_LOAD, 4'd9, 16'd120, 1'b0, 4'd9, 16'd120),
            pinned_row(MODE_LOAD, 4'd11, 16'd500, 1'b0, 4'd11, 16'd500),
            pinned_row(MODE_LOAD, 4'd6, 16'hAAAA, 1'b0, 4'd6, 16'hAAAA),
            pinned_row(MODE_LOAD, 4'd6, 16'h5555, 1'b0, 4'd6, 16'h5555),
            cmd_row(MODE_REQUEST, 4'd0, 16'd100),
            reg_row(REG_FIT_POLICY, 5'd1),
            // best fit with a tie between holes 4 and 9
            cmd_row(MODE_REQUEST, 4'd0, 16'd100),
            cmd_row(MODE_REQUEST, 4'd0, 16'd0),
            reg_row(REG_HOLE_COUNT, 5'd0),
            pinned_row(MODE_REQUEST, 4'd0, 16'd0, 1'b0, 4'd0, 16'd0),
            reg_row(REG_HOLE_COUNT, 5'd31),
            cmd_row(MODE_REQUEST, 4'd0, 16'd400),
            reg_row(REG_HOLE_COUNT, 5'd10),
            cmd_row(MODE_REQUEST, 4'd0, 16'd150),
            reg_row(REG_SPARE2, 5'd31),
            reg_row(REG_SPARE3, 5'd0),
            reg_row(REG_HOLE_COUNT, 5'd1),
            cmd_row(MODE_REQUEST, 4'd7, 16'd0),
            reg_row(REG_FIT_POLICY, 5'd0),
            reg_row(REG_HOLE_COUNT, 5'd16)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                issue_cmd(plan[i].cmd, plan[i].pinned, plan[i].want, $urandom_range(0, 14));
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            // upper data bits are don't-care for the policy register
            write_reg(REG_FIT_POLICY, {4'($urandom_range(0, 15)), 1'(ph % 2)});
            write_reg(REG_HOLE_COUNT, count_pick[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 19) == 0)
                    burst = !burst;
                gap = burst ? 0 : $urandom_range(0, 14);
                issue_cmd(draw_cmd(), 1'b0, '0, gap);
            end
        end

        start <= 1'b0;
        while (grant_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && grant_q.size() == 0)
            $display("fit_hole_allocator_core_test: PASS");
        else
            $display("fit_hole_allocator_core_test: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/fha_pkg.sv
hdl/fit_hole_allocator_core.sv
hdl/fha_checker.sv
tb/fit_hole_allocator_core_test.sv
